// ===== src/bmhq_pkg.sv =====
// Package for the binary min-heap queue: command and status codes,
// controller/datapath command and status structs. No dependencies.
package bmhq_pkg;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_PEEK    = 2'd2;
  localparam logic [1:0] CMD_REBUILD = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_LOAD    = 4'd1,  // capture input item, set up sift
    OP_RD      = 4'd2,  // issue memory reads for current step
    OP_EVAL    = 4'd3,  // compare read data, move or finish
    OP_WRITE   = 4'd4,  // write held entry at final position
    OP_NEXT    = 4'd5,  // rebuild: take next start index, read its slot
    OP_RDROOT  = 4'd6,  // read root slot and last slot
    OP_SETROOT = 4'd7,  // capture root output; on delete, start sift down
    OP_FETCH   = 4'd8   // rebuild: hold the entry read at the start index
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic done;      // sift finished after OP_EVAL
    logic rb_done;   // rebuild has no more start indices
  } dp_stat_t;

endpackage

// ===== src/bmhq_ctrl.sv =====
// Controller state machine of the binary min-heap queue.
// Depends on bmhq_pkg.
module bmhq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  output logic               out_valid,
  input  logic               out_ready,
  output bmhq_pkg::dp_cmd_t  dcmd,
  input  bmhq_pkg::dp_stat_t dstat
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_EVAL  = 9'b000000100,
    S_WRITE = 9'b000001000,
    S_ROOT  = 9'b000010000,
    S_SET   = 9'b000100000,
    S_OUT   = 9'b001000000,
    S_NEXT  = 9'b010000000,
    S_FETCH = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] cmd, cmd_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    dcmd.op    = bmhq_pkg::OP_NONE;
    dcmd.cmd   = cmd;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_next = command;
          dcmd.cmd = command;
          dcmd.op  = bmhq_pkg::OP_LOAD;
          case (command)
            bmhq_pkg::CMD_INSERT:
              state_next = dstat.full ? S_OUT : S_RD;
            bmhq_pkg::CMD_REBUILD:
              state_next = S_NEXT;
            default:
              state_next = dstat.empty ? S_OUT : S_ROOT;
          endcase
        end
      end
      S_NEXT: begin
        if (dstat.rb_done) begin
          state_next = S_OUT;
        end else begin
          dcmd.op    = bmhq_pkg::OP_NEXT;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        dcmd.op    = bmhq_pkg::OP_FETCH;
        state_next = S_RD;
      end
      S_ROOT: begin
        dcmd.op    = bmhq_pkg::OP_RDROOT;
        state_next = S_SET;
      end
      S_SET: begin
        dcmd.op    = bmhq_pkg::OP_SETROOT;
        state_next = (cmd == bmhq_pkg::CMD_PEEK) ? S_OUT : S_RD;
      end
      S_RD: begin
        dcmd.op    = bmhq_pkg::OP_RD;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        dcmd.op    = bmhq_pkg::OP_EVAL;
        state_next = dstat.done ? S_WRITE : S_RD;
      end
      S_WRITE: begin
        dcmd.op = bmhq_pkg::OP_WRITE;
        if (cmd == bmhq_pkg::CMD_REBUILD) begin
          state_next = S_NEXT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd   <= bmhq_pkg::CMD_INSERT;
    end else begin
      state <= state_next;
      cmd   <= cmd_next;
    end
  end

endmodule

// ===== src/bmhq_dpath.sv =====
// Datapath of the binary min-heap queue: entry memory, count, sift
// position and compare logic. Depends on bmhq_pkg.
module bmhq_dpath #(
  parameter int CAPACITY    = 1024,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_data,
  input  bmhq_pkg::dp_cmd_t                  dcmd,
  output bmhq_pkg::dp_stat_t                 dstat,
  input  logic [KEY_BITS-1:0]                arrival_key,
  input  logic [KEY_BITS-1:0]                boarding_key,
  input  logic [HANDLE_BITS-1:0]             handle,
  output logic [1:0]                         status,
  output logic                               item_valid,
  output logic [KEY_BITS-1:0]                out_arrival_key,
  output logic [KEY_BITS-1:0]                out_boarding_key,
  output logic [HANDLE_BITS-1:0]             out_handle,
  output logic [$clog2(CAPACITY+1)-1:0]      occupancy
);

  localparam int CB = $clog2(CAPACITY + 1);  // count bits
  localparam int AB = $clog2(CAPACITY);      // address bits (slot-1)
  localparam int EB = 2 * KEY_BITS + HANDLE_BITS;

  typedef logic [EB-1:0] entry_t;

  entry_t mem [CAPACITY];
  entry_t rd_a, rd_b;
  logic [AB-1:0] ra_a, ra_b;
  logic          wr_en;
  logic [AB-1:0] wr_addr;
  entry_t        wr_data;

  logic          mode;
  logic [CB-1:0] count;
  logic [CB:0]   pos;      // 1-based slot number, room for 2*pos
  logic [CB-1:0] rb_i;     // next rebuild start index
  entry_t        hold;
  logic          sift_up;

  logic [CB:0] kid;
  logic        done;
  logic [CB-1:0] cnt_last;

  function automatic logic [KEY_BITS-1:0] key_of(entry_t e, logic m);
    key_of = m ? e[EB-1 -: KEY_BITS] : e[EB-KEY_BITS-1 -: KEY_BITS];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

  assign dstat.full    = (count == CB'(CAPACITY));
  assign dstat.empty   = (count == '0);
  assign dstat.rb_done = (rb_i == '0);
  assign dstat.done    = done;
  assign cnt_last      = count - CB'(1);

  // read addresses: delete and peek read root and last slot; sift up reads
  // parent; sift down reads both kids; rebuild reads its start slot first
  always_comb begin
    ra_a = '0;
    ra_b = '0;
    if (dcmd.op == bmhq_pkg::OP_RDROOT) begin
      ra_a = '0;
      ra_b = cnt_last[AB-1:0];
    end else if (dcmd.op == bmhq_pkg::OP_NEXT) begin
      ra_a = AB'(rb_i - CB'(1));
    end else if (sift_up) begin
      ra_a = AB'((pos >> 1) - 1'b1);
    end else begin
      ra_a = AB'((pos << 1) - 1'b1);
      ra_b = AB'(pos << 1);
    end
  end

  // evaluation of one level
  logic [KEY_BITS-1:0] hk;
  always_comb begin
    hk   = key_of(hold, mode);
    kid  = pos << 1;
    done = 1'b1;
    if (sift_up) begin
      done = !(pos > 1 && hk < key_of(rd_a, mode));
    end else if (kid <= (CB+1)'(count)) begin
      if (kid != (CB+1)'(count) && key_of(rd_b, mode) < key_of(rd_a, mode))
        kid = kid + 1'b1;
      done = !(key_of((kid[0] ? rd_b : rd_a), mode) < hk);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AB'(pos - 1'b1);
    wr_data = hold;
    if (dcmd.op == bmhq_pkg::OP_EVAL && !done) begin
      wr_en   = 1'b1;
      wr_data = sift_up ? rd_a : (kid[0] ? rd_b : rd_a);
    end else if (dcmd.op == bmhq_pkg::OP_WRITE) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b1;
      count <= '0;
      rb_i  <= '0;
      sift_up <= 1'b0;
    end else begin
      if (cfg_valid) mode <= cfg_data;
      case (dcmd.op)
        bmhq_pkg::OP_LOAD: begin
          status     <= bmhq_pkg::ST_OK;
          item_valid <= 1'b0;
          out_arrival_key  <= '0;
          out_boarding_key <= '0;
          out_handle       <= '0;
          sift_up <= (dcmd.cmd == bmhq_pkg::CMD_INSERT);
          case (dcmd.cmd)
            bmhq_pkg::CMD_INSERT: begin
              if (dstat.full) begin
                status <= bmhq_pkg::ST_FULL;
              end else begin
                count <= count + CB'(1);
                pos   <= (CB+1)'(count) + 1'b1;
                hold  <= {arrival_key, boarding_key, handle};
              end
            end
            bmhq_pkg::CMD_REBUILD: begin
              rb_i <= count >> 1;
            end
            default: begin
              if (dstat.empty) status <= bmhq_pkg::ST_EMPTY;
            end
          endcase
        end
        bmhq_pkg::OP_SETROOT: begin
          item_valid       <= 1'b1;
          out_arrival_key  <= rd_a[EB-1 -: KEY_BITS];
          out_boarding_key <= rd_a[EB-KEY_BITS-1 -: KEY_BITS];
          out_handle       <= rd_a[HANDLE_BITS-1:0];
          if (dcmd.cmd == bmhq_pkg::CMD_DELETE) begin
            count <= cnt_last;
            hold  <= rd_b;
            pos   <= (CB+1)'(1);
          end
        end
        bmhq_pkg::OP_NEXT: begin
          pos  <= (CB+1)'(rb_i);
          rb_i <= rb_i - CB'(1);
        end
        bmhq_pkg::OP_FETCH: begin
          hold <= rd_a;
        end
        bmhq_pkg::OP_EVAL: begin
          if (!done) pos <= sift_up ? (pos >> 1) : kid;
        end
        default: ;
      endcase
    end
  end

  assign occupancy = count;

endmodule

// ===== src/binary_min_heap_queue.sv =====
// Binary min-heap priority queue, top level. One item at a time: insert
// sifts the new entry up, delete moves the last entry to the root and sifts it
// down, peek reads the root, empty or full commands are rejected, and rebuild
// sifts down each internal node from the last one to the root. Each level is a
// read step and a compare step; the result is offered in the output state.
// Synchronous reset clears the count and orders by arrival key; memory kept.
module binary_min_heap_queue #(
  parameter int CAPACITY    = 1024,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [KEY_BITS-1:0]           arrival_key,
  input  logic [KEY_BITS-1:0]           boarding_key,
  input  logic [HANDLE_BITS-1:0]        handle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic                          item_valid,
  output logic [KEY_BITS-1:0]           out_arrival_key,
  output logic [KEY_BITS-1:0]           out_boarding_key,
  output logic [HANDLE_BITS-1:0]        out_handle,
  output logic [$clog2(CAPACITY+1)-1:0] occupancy
);

  bmhq_pkg::dp_cmd_t  dcmd;
  bmhq_pkg::dp_stat_t dstat;

  // mode register taken only while idle, so no sift sees it change midway;
  // a write on the edge that takes an item applies to that item
  assign cfg_ready = in_ready;

  bmhq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .command,
    .out_valid, .out_ready, .dcmd, .dstat
  );

  bmhq_dpath #(
    .CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)
  ) u_dpath (
    .clk, .rst, .cfg_valid(cfg_valid && cfg_ready), .cfg_data, .dcmd, .dstat,
    .arrival_key, .boarding_key, .handle,
    .status, .item_valid, .out_arrival_key, .out_boarding_key,
    .out_handle, .occupancy
  );

endmodule
